// ===== src/stable_max_priority_queue_core_defines.svh =====
// Assertion macros shared by the priority queue RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef STABLE_MAX_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define STABLE_MAX_PRIORITY_QUEUE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define SMPQ_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("priority queue check failed");
// Next-cycle implication, disabled while reset is asserted.
`define SMPQ_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("priority queue check failed");
`else
`define SMPQ_ASSERT_IMP(label, clk, rstn, ante, cons)
`define SMPQ_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== src/smpq_pkg.sv =====
// Package for the stable max-first priority queue: widths, codes and shared types.
// Used by smpq_cell and stable_max_priority_queue_core; no dependencies.
package smpq_pkg;

    localparam int SMPQ_DEPTH = 8;
    localparam int VALUE_W    = 32;
    localparam int PRIO_W     = 16;
    localparam int OCC_W      = 4;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_PEEK   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic signed [PRIO_W-1:0]  prio;
    } smpq_item_t;

    typedef struct packed {
        logic ins;
        logic rem;
    } smpq_ctl_t;

endpackage

// ===== src/smpq_cell.sv =====
// One slot of the sorted shift-register queue.
// Depends on smpq_pkg for the item and control types.
module smpq_cell
    import smpq_pkg::*;
#(
    parameter int DEPTH = SMPQ_DEPTH,
    parameter int INDEX = 0,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             aclk,
    input  smpq_ctl_t        ctl,
    input  smpq_item_t       new_item,
    input  logic [CNT_W-1:0] count,
    input  logic             left_gt,
    input  smpq_item_t       left_item,
    input  smpq_item_t       right_item,
    output logic             gt,
    output smpq_item_t       item
);

    localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

    smpq_item_t item_reg;
    smpq_item_t item_next;

    // The new item belongs before this slot if the slot is empty or holds a
    // strictly lower priority; equal priorities keep the older entry in front.
    assign gt = (IDX >= count) || (new_item.prio > item_reg.prio);

    always_comb begin
        item_next = item_reg;
        priority if (ctl.rem) begin
            item_next = right_item;
        end else if (ctl.ins && gt) begin
            item_next = left_gt ? left_item : new_item;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    assign item = item_reg;

endmodule

// ===== src/stable_max_priority_queue_core.sv =====
// Stable max-first priority queue built as a chain of sorted cells.
// Depends on smpq_pkg, smpq_cell and stable_max_priority_queue_core_defines.svh.
//
// Usage: each transaction on the s_ channel carries an operation in s_mode
// (insert, remove highest, peek highest) together with s_value and s_prio.
// Every accepted transaction produces exactly one transaction on the m_
// channel with a status, the removed or peeked pair, and the occupancy after
// the operation. Entries are kept sorted by descending signed priority, with
// equal priorities in arrival order, so the head cell always holds the entry
// to be served. An insert is placed by a local compare in every cell and the
// later cells shift one place back; a remove shifts every cell one place
// forward. m_valid rises in the cycle after acceptance, and one transaction
// can be accepted every cycle while the receiver keeps up, as all cells
// move at once. The result register decouples the two sides: s_ready is high
// whenever the result register is empty or is being emptied in this cycle,
// so a stalled receiver holds the result and blocks only further input.
// A synchronous low aresetn empties the queue and drops any pending result;
// the cell contents themselves are not cleared, as only occupied cells are
// ever read.
`include "stable_max_priority_queue_core_defines.svh"

module stable_max_priority_queue_core
    import smpq_pkg::*;
#(
    parameter int DEPTH = SMPQ_DEPTH
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_mode,
    input  logic signed [VALUE_W-1:0] s_value,
    input  logic signed [PRIO_W-1:0]  s_prio,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_status,
    output logic signed [VALUE_W-1:0] m_out_value,
    output logic signed [PRIO_W-1:0]  m_out_prio,
    output logic [OCC_W-1:0]          m_occupancy
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic             s_fire;
    smpq_ctl_t        ctl;
    smpq_item_t       new_item;
    smpq_item_t       cell_item [DEPTH];
    logic             cell_gt   [DEPTH];
    smpq_item_t       head;
    logic             is_full;
    logic             is_empty;
    logic             full_fire;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic [1:0]       status_reg;
    logic [1:0]       status_next;
    smpq_item_t       res_reg;
    smpq_item_t       res_next;
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;
    logic [CNT_W+OCC_W-1:0] occ_wide;

    assign s_ready        = !m_valid_reg || m_ready;
    assign s_fire         = s_valid && s_ready;
    assign new_item.value = s_value;
    assign new_item.prio  = s_prio;
    assign head           = cell_item[0];
    assign is_full        = (cnt_reg == CNT_W'(DEPTH));
    assign is_empty       = (cnt_reg == '0);
    assign full_fire      = s_fire && (s_mode == MODE_INSERT) && is_full;

    // The chain: each cell looks at its left neighbour for inserts and at its
    // right neighbour for removals. The tail cell refills from itself on a
    // remove, which only ever lands in a slot that has just become empty.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic       left_gt;
        smpq_item_t left_item;
        smpq_item_t right_item;

        if (i == 0) begin : g_first
            assign left_gt   = 1'b0;
            assign left_item = new_item;
        end else begin : g_mid
            assign left_gt   = cell_gt[i-1];
            assign left_item = cell_item[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_item = cell_item[i];
        end else begin : g_inner
            assign right_item = cell_item[i+1];
        end

        smpq_cell #(
            .DEPTH (DEPTH),
            .INDEX (i)
        ) u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .new_item   (new_item),
            .count      (cnt_reg),
            .left_gt    (left_gt),
            .left_item  (left_item),
            .right_item (right_item),
            .gt         (cell_gt[i]),
            .item       (cell_item[i])
        );
    end

    // Operation decode. The chain is only told to move on an accepted
    // transaction, and never on a rejected insert or an empty remove.
    always_comb begin
        ctl         = '0;
        status_next = ST_OK;
        res_next    = '0;
        cnt_next    = cnt_reg;
        unique case (s_mode)
            MODE_INSERT: begin
                if (is_full) begin
                    status_next = ST_FULL;
                end else begin
                    ctl.ins  = s_fire;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            MODE_REMOVE: begin
                if (is_empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    ctl.rem  = s_fire;
                    res_next = head;
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            MODE_PEEK: begin
                if (is_empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    res_next = head;
                end
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
    end

    // Occupancy is reported modulo the width of its field.
    assign occ_wide = {{OCC_W{1'b0}}, cnt_next};
    assign occ_next = occ_wide[OCC_W-1:0];

    always_comb begin
        m_valid_next = m_valid_reg;
        priority if (s_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_fire) begin
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            status_reg <= status_next;
            res_reg    <= res_next;
            occ_reg    <= occ_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = status_reg;
    assign m_out_value = res_reg.value;
    assign m_out_prio  = res_reg.prio;
    assign m_occupancy = occ_reg;

    // The fill level never passes the number of cells.
    `SMPQ_ASSERT_IMP(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= CNT_W'(DEPTH))
    // A successful insert grows the queue by exactly one entry.
    `SMPQ_ASSERT_NXT(a_ins_grow, aclk, aresetn, ctl.ins, cnt_reg == $past(cnt_reg) + CNT_W'(1))
    // A remove hands out the entry that stood in the head cell.
    `SMPQ_ASSERT_NXT(a_rem_head, aclk, aresetn, ctl.rem, res_reg == $past(head))
    // An insert into a full queue is answered with a valid result of full status.
    `SMPQ_ASSERT_NXT(a_full_stat, aclk, aresetn, full_fire, m_status == ST_FULL && m_valid)

endmodule

// ===== bench/tb_stable_max_priority_queue_core.sv =====
// Self-checking testbench for stable_max_priority_queue_core.
// Holds its own priority queue predictor, a valid/ready driver and a result monitor.
// Depends on smpq_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_stable_max_priority_queue_core;
    import smpq_pkg::*;

    // The fourth mode encoding is unused by the block; it must act as a no-operation.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int RANDOM_OPS       = 1700;
    localparam int CYCLE_LIMIT      = 1000000;
    localparam int LONG_HOLD_AT     = 400;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int SETTLE_CYCLES    = 8;
    localparam int PRINT_CAP        = 100;

    // One operation waiting to be offered on the s_ channel. When drain_first is set,
    // the driver withholds it until every outstanding result has been returned.
    typedef struct {
        logic [1:0]                mode;
        logic signed [VALUE_W-1:0] value;
        logic signed [PRIO_W-1:0]  prio;
        logic                      drain_first;
    } queue_op_t;

    typedef struct {
        logic [1:0]                status;
        logic signed [VALUE_W-1:0] out_value;
        logic signed [PRIO_W-1:0]  out_prio;
        logic [OCC_W-1:0]          occupancy;
    } queue_result_t;

    logic                      aclk    = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [1:0]                s_mode  = MODE_INSERT;
    logic signed [VALUE_W-1:0] s_value = '0;
    logic signed [PRIO_W-1:0]  s_prio  = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [1:0]                m_status;
    logic signed [VALUE_W-1:0] m_out_value;
    logic signed [PRIO_W-1:0]  m_out_prio;
    logic [OCC_W-1:0]          m_occupancy;

    // Operations still to be offered, and the results that accepted operations owe us.
    queue_op_t     op_backlog[$];
    queue_result_t awaited_results[$];

    // Predicted contents of the queue, oldest entry at index zero.
    logic signed [VALUE_W-1:0] held_value[$];
    logic signed [PRIO_W-1:0]  held_prio[$];

    int            mismatch_count = 0;
    int            cycle_count    = 0;
    int            results_seen   = 0;
    logic          item_taken     = 1'b0;
    logic          result_taken   = 1'b0;
    queue_result_t want;

    // Driver and receiver pacing state.
    int        send_wait  = 0;
    int        send_calm  = 0;
    int        send_gap;
    int        recv_wait  = 0;
    int        recv_calm  = 0;
    int        recv_gap;
    logic      hold_done  = 1'b0;
    queue_op_t next_op;

    stable_max_priority_queue_core u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_value     (s_value),
        .s_prio      (s_prio),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_out_value (m_out_value),
        .m_out_prio  (m_out_prio),
        .m_occupancy (m_occupancy)
    );

    always #5 aclk = ~aclk;

    // Applies one operation to the predicted queue and returns the result it should give.
    // A remove or peek serves the greatest signed priority; the strict comparison keeps
    // the oldest entry among equal priorities, and deleting from the queue closes the gap
    // while keeping arrival order.
    function automatic queue_result_t serve_operation(input logic [1:0] mode,
                                                      input logic signed [VALUE_W-1:0] value,
                                                      input logic signed [PRIO_W-1:0] prio);
        queue_result_t res;
        int            best;
        int            i;
        res.status    = ST_OK;
        res.out_value = '0;
        res.out_prio  = '0;
        case (mode)
            MODE_INSERT: begin
                if (held_prio.size() >= SMPQ_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    held_value.push_back(value);
                    held_prio.push_back(prio);
                end
            end
            MODE_REMOVE, MODE_PEEK: begin
                if (held_prio.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    best = 0;
                    for (i = 1; i < held_prio.size(); i++) begin
                        if (held_prio[i] > held_prio[best]) begin
                            best = i;
                        end
                    end
                    res.out_value = held_value[best];
                    res.out_prio  = held_prio[best];
                    if (mode == MODE_REMOVE) begin
                        held_value.delete(best);
                        held_prio.delete(best);
                    end
                end
            end
            default: begin
            end
        endcase
        res.occupancy = OCC_W'(held_prio.size());
        return res;
    endfunction

    // Gap lengths: mostly none or short, occasionally long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        if (mismatch_count < PRINT_CAP) begin
            $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got,
                     exp_val);
        end
        mismatch_count++;
    endtask

    task automatic add_op(input logic [1:0] mode, input logic signed [VALUE_W-1:0] value,
                          input logic signed [PRIO_W-1:0] prio, input logic drain_first);
        queue_op_t op;
        op.mode        = mode;
        op.value       = value;
        op.prio        = prio;
        op.drain_first = drain_first;
        op_backlog.push_back(op);
    endtask

    // Rising edge: the cycle limit, the result monitor and input acceptance. The result
    // check comes before the new expectation is queued, so that a result arriving in the
    // same cycle as an accepted transaction is always matched against an older one.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            item_taken   <= aresetn && s_valid && s_ready;
            result_taken <= aresetn && m_valid && m_ready;
            if (aresetn && m_valid && m_ready) begin
                results_seen++;
                if (awaited_results.size() == 0) begin
                    report_mismatch("unexpected result", 32'(m_status), 32'(ST_OK));
                end else begin
                    want = awaited_results.pop_front();
                    if (m_status !== want.status) begin
                        report_mismatch("status", 32'(m_status), 32'(want.status));
                    end
                    if (m_out_value !== want.out_value) begin
                        report_mismatch("out_value", m_out_value, want.out_value);
                    end
                    if (m_out_prio !== want.out_prio) begin
                        report_mismatch("out_prio", 32'(m_out_prio), 32'(want.out_prio));
                    end
                    if (m_occupancy !== want.occupancy) begin
                        report_mismatch("occupancy", 32'(m_occupancy), 32'(want.occupancy));
                    end
                end
            end
            if (aresetn && s_valid && s_ready) begin
                awaited_results.push_back(serve_operation(s_mode, s_value, s_prio));
            end
        end
    end

    // Driver. A new transaction is only presented once the previous one has been
    // accepted, so the payload stays put while valid is high. Every branch gives s_valid
    // exactly one update, so a back-to-back transaction keeps valid high throughout.
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || item_taken)) begin
            if (send_wait != 0) begin
                send_wait <= send_wait - 1;
                s_valid   <= 1'b0;
            end else if (op_backlog.size() != 0 &&
                         (!op_backlog[0].drain_first || awaited_results.size() == 0)) begin
                next_op = op_backlog.pop_front();
                s_mode  <= next_op.mode;
                s_value <= next_op.value;
                s_prio  <= next_op.prio;
                s_valid <= 1'b1;
                // Now and then run a stretch of transactions with no gaps at all.
                if (send_calm != 0) begin
                    send_calm--;
                    send_gap = 0;
                end else begin
                    if ($urandom_range(0, 149) == 0) begin
                        send_calm = 60;
                    end
                    send_gap = pick_gap();
                end
                send_wait <= send_gap;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver. Stalls for a random gap after each result, with stretches of none, and
    // once holds off for a long stretch while the sender keeps offering, so that the
    // result register stays full and the block has to refuse input.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (!hold_done && results_seen >= LONG_HOLD_AT) begin
            hold_done <= 1'b1;
            recv_wait <= LONG_HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (recv_wait != 0) begin
            recv_wait <= recv_wait - 1;
            m_ready   <= (recv_wait == 1);
        end else if (result_taken) begin
            if (recv_calm != 0) begin
                recv_calm--;
                recv_gap = 0;
            end else begin
                if ($urandom_range(0, 149) == 0) begin
                    recv_calm = 60;
                end
                recv_gap = pick_gap();
            end
            recv_wait <= recv_gap;
            m_ready   <= (recv_gap == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin : stimulus
        int                        n;
        int                        r;
        int                        bias;
        int                        ins_pct;
        logic [1:0]                mode;
        logic signed [VALUE_W-1:0] value;
        logic signed [PRIO_W-1:0]  prio;

        // Directed part. An empty queue refuses remove and peek, and the unused mode
        // does nothing.
        add_op(MODE_REMOVE, 32'sh1234_5678, 16'sh7FFF, 1'b0);
        add_op(MODE_PEEK,   32'shFFFF_FFFF, 16'sh8000, 1'b0);
        add_op(MODE_UNUSED, 32'shFFFF_FFFF, 16'shFFFF, 1'b0);
        // Fill to capacity with extreme values and priorities, including ties at both
        // ends of the priority range so that the oldest-first rule is exercised.
        add_op(MODE_INSERT, 32'sh7FFF_FFFF, 16'sh8000, 1'b0);
        add_op(MODE_INSERT, 32'sh8000_0000, 16'sh7FFF, 1'b0);
        add_op(MODE_INSERT, 32'sh0000_0000, 16'sh0000, 1'b0);
        add_op(MODE_INSERT, 32'shFFFF_FFFF, 16'shFFFF, 1'b0);
        add_op(MODE_INSERT, 32'sh0000_0001, 16'sh7FFF, 1'b0);
        add_op(MODE_INSERT, 32'sh0000_0002, 16'sh8000, 1'b0);
        add_op(MODE_INSERT, 32'sh0000_0003, 16'sh0000, 1'b0);
        add_op(MODE_INSERT, 32'sh5555_AAAA, 16'sh7FFF, 1'b0);
        // A full queue rejects an insert; peek and the unused mode leave it alone.
        add_op(MODE_INSERT, 32'shDEAD_BEEF, 16'sh7FFF, 1'b0);
        add_op(MODE_PEEK,   32'sh0000_0000, 16'sh0000, 1'b0);
        add_op(MODE_UNUSED, 32'sh0000_0000, 16'sh0000, 1'b0);
        // Drain completely, then remove once more from the empty queue.
        for (n = 0; n < SMPQ_DEPTH + 1; n++) begin
            add_op(MODE_REMOVE, 32'(n), 16'(n), 1'b0);
        end

        // Random part, in phases that lean towards filling, draining or neither, so
        // that both the full and the empty cases keep coming round. Priorities are
        // drawn from a narrow band half of the time, to produce plenty of ties.
        bias = 0;
        for (n = 0; n < RANDOM_OPS; n++) begin
            if (n % 100 == 0) begin
                bias = $urandom_range(0, 2);
            end
            ins_pct = (bias == 0) ? 70 : (bias == 1) ? 30 : 50;
            r = $urandom_range(0, 99);
            if (r < 3) begin
                mode = MODE_UNUSED;
            end else begin
                r = $urandom_range(0, 99);
                if (r < ins_pct) begin
                    mode = MODE_INSERT;
                end else if (r < ins_pct + ((100 - ins_pct) * 3) / 4) begin
                    mode = MODE_REMOVE;
                end else begin
                    mode = MODE_PEEK;
                end
            end
            case ($urandom_range(0, 7))
                0: value = 32'sh7FFF_FFFF;
                1: value = 32'sh8000_0000;
                2: value = 32'sh0000_0000;
                3: value = 32'shFFFF_FFFF;
                default: value = $urandom;
            endcase
            case ($urandom_range(0, 3))
                0, 1: prio = 16'(int'($urandom_range(0, 6)) - 3);
                2: prio = 16'($urandom);
                default: begin
                    case ($urandom_range(0, 3))
                        0: prio = 16'sh8000;
                        1: prio = 16'sh7FFF;
                        2: prio = 16'sh0000;
                        default: prio = 16'shFFFF;
                    endcase
                end
            endcase
            add_op(mode, value, prio, (n % 250 == 0));
        end

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Run until everything has been offered, accepted and answered, then let the
        // settle cycles pass in case a stray result follows.
        do begin
            @(posedge aclk);
        end while (op_backlog.size() != 0 || s_valid || awaited_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
